>>> rtl/arc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package arc_pkg;

   localparam int COORD_BITS  = 12;
   localparam int FRAC_BITS   = 15;
   localparam int REG_W       = 32;
   localparam int NUM_CFG     = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int ST_W        = FRAC_BITS + 1;
   localparam int OUT_W       = 16;
   localparam int NUM_ROT     = 9;
   localparam int ACC_W       = 64;
   localparam int OPND_W      = 32;
   localparam int BALL_FRAC   = 24;
   localparam int BALL_W      = REG_W + COORD_BITS + 2;
   localparam int UX_W        = BALL_W - 1;
   localparam int LIM_BITS    = 30;
   localparam int MAG_W       = 2 * LIM_BITS + 1;
   localparam int ROOT_W      = LIM_BITS + 1;
   localparam int SQRT_STEPS  = LIM_BITS + 1;
   localparam int DIV_STEPS   = FRAC_BITS + 2;
   localparam int PT_W        = DIV_STEPS;
   localparam int DVS_W       = ROOT_W + DIV_STEPS - 1;
   localparam int RND_SH      = BALL_FRAC - FRAC_BITS;
   localparam int PC_W        = 6;
   localparam int CNT_W       = 5;

   localparam logic [PC_W-1:0] PC_EMIT = PC_W'(39);

   localparam logic signed [ACC_W-1:0] ST_MAX  = (64'sd1 <<< FRAC_BITS) - 64'sd1;
   localparam logic signed [ACC_W-1:0] ST_MIN  = -(64'sd1 <<< FRAC_BITS);
   localparam logic signed [ACC_W-1:0] HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] ONE_SQ  = 64'sd1 <<< (2 * FRAC_BITS);
   localparam logic [MAG_W-1:0]        ONE_MAG = MAG_W'(1) << (2 * BALL_FRAC);

   typedef enum logic [2:0] {
      ST_IDLE, ST_RUN, ST_ACC, ST_ITER, ST_WAIT
   } arc_state_type;

   typedef enum logic [3:0] {
      CMD_NOP, CMD_LOAD, CMD_MUL, CMD_ACC, CMD_ABS, CMD_SHIFT, CMD_SQRT_INIT,
      CMD_SQRT_STEP, CMD_DIV_INIT, CMD_DIV_STEP, CMD_POINT, CMD_PUBLISH
   } arc_cmd_type;

   typedef enum logic [2:0] {
      UOP_MAC, UOP_ABS, UOP_SHIFT, UOP_SQRT, UOP_DIVX, UOP_DIVY, UOP_POINT, UOP_END
   } arc_kind_type;

   typedef enum logic [4:0] {
      OP_R0, OP_R1, OP_R2, OP_R3, OP_R4, OP_R5, OP_SX, OP_SY, OP_ONE, OP_UX, OP_UY,
      OP_F0, OP_F1, OP_F2, OP_T0, OP_T1, OP_T2, OP_D0, OP_D1, OP_D2, OP_D3,
      OP_Q0, OP_Q1, OP_Q2, OP_Q3, OP_C0, OP_C1, OP_C2, OP_C3
   } arc_opnd_type;

   typedef enum logic [4:0] {
      DST_NONE, DST_BX, DST_BY, DST_MAG, DST_D0, DST_D1, DST_D2, DST_D3,
      DST_C0, DST_C1, DST_C2, DST_C3, DST_M0, DST_M1, DST_M2, DST_M3, DST_M4,
      DST_M5, DST_M6, DST_M7, DST_M8
   } arc_dst_type;

   typedef struct packed {
      arc_kind_type kind;
      arc_opnd_type a;
      arc_opnd_type b;
      logic         sub;
      logic         first;
      logic         last;
      arc_dst_type  dst;
   } arc_uop_type;

   typedef struct packed {
      arc_cmd_type  cmd;
      arc_opnd_type a;
      arc_opnd_type b;
      logic         sub;
      logic         first;
      logic         last;
      arc_dst_type  dst;
      logic         div_y;
   } arc_ctl_type;

   typedef struct packed {
      logic begin_drag;
      logic big;
      logic rim;
      logic out_free;
   } arc_sts_type;

   function automatic arc_uop_type mac(input arc_opnd_type a, input arc_opnd_type b,
                                       input logic sub, input logic first,
                                       input logic last, input arc_dst_type dst);
      arc_uop_type u;
      u.kind  = UOP_MAC;
      u.a     = a;
      u.b     = b;
      u.sub   = sub;
      u.first = first;
      u.last  = last;
      u.dst   = dst;
      return u;
   endfunction

   function automatic arc_uop_type ctl_uop(input arc_kind_type kind);
      arc_uop_type u;
      u       = '0;
      u.kind  = kind;
      u.dst   = DST_NONE;
      return u;
   endfunction

   // Microprogram: projection, delta quaternion, quaternion product, matrix.
   function automatic arc_uop_type arc_uop(input logic [PC_W-1:0] pc);
      arc_uop_type u;
      case (pc)
         6'd0:  u = mac(OP_R0, OP_SX, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd1:  u = mac(OP_R1, OP_SY, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd2:  u = mac(OP_R2, OP_ONE, 1'b0, 1'b0, 1'b1, DST_BX);
         6'd3:  u = mac(OP_R3, OP_SX, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd4:  u = mac(OP_R4, OP_SY, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd5:  u = mac(OP_R5, OP_ONE, 1'b0, 1'b0, 1'b1, DST_BY);
         6'd6:  u = ctl_uop(UOP_ABS);
         6'd7:  u = ctl_uop(UOP_SHIFT);
         6'd8:  u = mac(OP_UX, OP_UX, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd9:  u = mac(OP_UY, OP_UY, 1'b0, 1'b0, 1'b1, DST_MAG);
         6'd10: u = ctl_uop(UOP_SQRT);
         6'd11: u = ctl_uop(UOP_DIVX);
         6'd12: u = ctl_uop(UOP_DIVY);
         6'd13: u = ctl_uop(UOP_POINT);
         6'd14: u = mac(OP_F0, OP_T0, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd15: u = mac(OP_F1, OP_T1, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd16: u = mac(OP_F2, OP_T2, 1'b0, 1'b0, 1'b1, DST_D0);
         6'd17: u = mac(OP_F1, OP_T2, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd18: u = mac(OP_F2, OP_T1, 1'b1, 1'b0, 1'b1, DST_D1);
         6'd19: u = mac(OP_F2, OP_T0, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd20: u = mac(OP_F0, OP_T2, 1'b1, 1'b0, 1'b1, DST_D2);
         6'd21: u = mac(OP_F0, OP_T1, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd22: u = mac(OP_F1, OP_T0, 1'b1, 1'b0, 1'b1, DST_D3);
         6'd23: u = mac(OP_D0, OP_Q0, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd24: u = mac(OP_D1, OP_Q1, 1'b1, 1'b0, 1'b0, DST_NONE);
         6'd25: u = mac(OP_D2, OP_Q2, 1'b1, 1'b0, 1'b0, DST_NONE);
         6'd26: u = mac(OP_D3, OP_Q3, 1'b1, 1'b0, 1'b1, DST_C0);
         6'd27: u = mac(OP_D0, OP_Q1, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd28: u = mac(OP_D1, OP_Q0, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd29: u = mac(OP_D2, OP_Q3, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd30: u = mac(OP_D3, OP_Q2, 1'b1, 1'b0, 1'b1, DST_C1);
         6'd31: u = mac(OP_D0, OP_Q2, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd32: u = mac(OP_D1, OP_Q3, 1'b1, 1'b0, 1'b0, DST_NONE);
         6'd33: u = mac(OP_D2, OP_Q0, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd34: u = mac(OP_D3, OP_Q1, 1'b0, 1'b0, 1'b1, DST_C2);
         6'd35: u = mac(OP_D0, OP_Q3, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd36: u = mac(OP_D1, OP_Q2, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd37: u = mac(OP_D2, OP_Q1, 1'b1, 1'b0, 1'b0, DST_NONE);
         6'd38: u = mac(OP_D3, OP_Q0, 1'b0, 1'b0, 1'b1, DST_C3);
         6'd39: u = mac(OP_C2, OP_C2, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd40: u = mac(OP_C3, OP_C3, 1'b0, 1'b0, 1'b1, DST_M0);
         6'd41: u = mac(OP_C1, OP_C2, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd42: u = mac(OP_C0, OP_C3, 1'b0, 1'b0, 1'b1, DST_M1);
         6'd43: u = mac(OP_C1, OP_C3, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd44: u = mac(OP_C0, OP_C2, 1'b1, 1'b0, 1'b1, DST_M2);
         6'd45: u = mac(OP_C1, OP_C2, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd46: u = mac(OP_C0, OP_C3, 1'b1, 1'b0, 1'b1, DST_M3);
         6'd47: u = mac(OP_C1, OP_C1, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd48: u = mac(OP_C3, OP_C3, 1'b0, 1'b0, 1'b1, DST_M4);
         6'd49: u = mac(OP_C2, OP_C3, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd50: u = mac(OP_C0, OP_C1, 1'b0, 1'b0, 1'b1, DST_M5);
         6'd51: u = mac(OP_C1, OP_C3, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd52: u = mac(OP_C0, OP_C2, 1'b0, 1'b0, 1'b1, DST_M6);
         6'd53: u = mac(OP_C2, OP_C3, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd54: u = mac(OP_C0, OP_C1, 1'b1, 1'b0, 1'b1, DST_M7);
         6'd55: u = mac(OP_C1, OP_C1, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd56: u = mac(OP_C2, OP_C2, 1'b0, 1'b0, 1'b1, DST_M8);
         default: u = ctl_uop(UOP_END);
      endcase
      return u;
   endfunction

endpackage

`default_nettype wire

>>> rtl/arcball_drag_rotation_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Arcball drag rotation. Each pointer word (begin-drag or drag, screen x/y) is
// mapped through the six Q8.24 csr coefficients onto the unit ball; a begin-drag
// latches the current quaternion and the down point, a drag builds the delta
// quaternion, multiplies it onto the down quaternion and the block returns the
// 3x3 rotation matrix (Q1.15, saturated) of the conjugate. Every accepted word
// produces exactly one result word. One word is processed at a time: req_stall
// is high from acceptance until the matrix is in the output register. The work
// per word is set by the single shared 32x32 multiply-accumulate (51 products
// for a drag, 26 for a begin-drag), the 31-step square root and, for points
// outside the disc, two 17-step divisions plus up to 14 range-reduction shifts.
// A result that still waits on rsp_stall when the next matrix is ready holds
// the block until it is taken. The next word is accepted while the previous
// result still waits on rsp_stall. Write csr registers only while the block is
// idle; indexes past the last register are dropped.

module arcball_drag_rotation_unit
   import arc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_opcode,
   input  wire logic [COORD_BITS-1:0]  req_screen_x,
   input  wire logic [COORD_BITS-1:0]  req_screen_y,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic signed [OUT_W-1:0]     rsp_rot_00,
   output logic signed [OUT_W-1:0]     rsp_rot_01,
   output logic signed [OUT_W-1:0]     rsp_rot_02,
   output logic signed [OUT_W-1:0]     rsp_rot_10,
   output logic signed [OUT_W-1:0]     rsp_rot_11,
   output logic signed [OUT_W-1:0]     rsp_rot_12,
   output logic signed [OUT_W-1:0]     rsp_rot_20,
   output logic signed [OUT_W-1:0]     rsp_rot_21,
   output logic signed [OUT_W-1:0]     rsp_rot_22,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [REG_W-1:0]       csr_wdata
);

   arc_ctl_type            ctl;
   arc_sts_type            sts;
   logic signed [OUT_W-1:0] rot [NUM_ROT];

   // Sequencer: walks the microprogram and steps the iterative units.
   arc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   // Datapath: csr file, shared multiply-accumulate, root, divider, output word.
   arc_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .sts          (sts),
      .req_opcode   (req_opcode),
      .req_screen_x (req_screen_x),
      .req_screen_y (req_screen_y),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rot          (rot)
   );

   // Row-major matrix onto the result ports.
   assign rsp_rot_00 = rot[0];
   assign rsp_rot_01 = rot[1];
   assign rsp_rot_02 = rot[2];
   assign rsp_rot_10 = rot[3];
   assign rsp_rot_11 = rot[4];
   assign rsp_rot_12 = rot[5];
   assign rsp_rot_20 = rot[6];
   assign rsp_rot_21 = rot[7];
   assign rsp_rot_22 = rot[8];

endmodule

`default_nettype wire

>>> rtl/arc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module arc_ctrl
   import arc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire arc_sts_type sts,
   output arc_ctl_type      ctl
);

   arc_state_type    state_ff, state_in;
   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   arc_uop_type      uop;

   assign uop = arc_uop(pc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state, program counter and iteration count.
   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
               pc_in    = '0;
            end
         end
         ST_RUN: begin
            unique case (uop.kind)
               UOP_MAC: state_in = ST_ACC;
               UOP_ABS: pc_in = pc_ff + 1'b1;
               UOP_SHIFT: begin
                  if (!sts.big) pc_in = pc_ff + 1'b1;
               end
               UOP_SQRT: begin
                  cnt_in   = CNT_W'(SQRT_STEPS - 1);
                  state_in = ST_ITER;
               end
               UOP_DIVX, UOP_DIVY: begin
                  if (sts.rim) begin
                     cnt_in   = CNT_W'(DIV_STEPS - 1);
                     state_in = ST_ITER;
                  end else begin
                     pc_in = pc_ff + 1'b1;
                  end
               end
               UOP_POINT: pc_in = sts.begin_drag ? PC_EMIT : pc_ff + 1'b1;
               UOP_END:   state_in = ST_WAIT;
               default:   state_in = ST_WAIT;
            endcase
         end
         ST_ACC: begin
            pc_in    = pc_ff + 1'b1;
            state_in = ST_RUN;
         end
         ST_ITER: begin
            if (cnt_ff == '0) begin
               pc_in    = pc_ff + 1'b1;
               state_in = ST_RUN;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_WAIT: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      ctl       = '0;
      ctl.cmd   = CMD_NOP;
      ctl.a     = uop.a;
      ctl.b     = uop.b;
      ctl.sub   = uop.sub;
      ctl.first = uop.first;
      ctl.last  = uop.last;
      ctl.dst   = uop.dst;
      ctl.div_y = (uop.kind == UOP_DIVY);
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) ctl.cmd = CMD_LOAD;
         end
         ST_RUN: begin
            unique case (uop.kind)
               UOP_MAC:   ctl.cmd = CMD_MUL;
               UOP_ABS:   ctl.cmd = CMD_ABS;
               UOP_SHIFT: ctl.cmd = sts.big ? CMD_SHIFT : CMD_NOP;
               UOP_SQRT:  ctl.cmd = CMD_SQRT_INIT;
               UOP_DIVX, UOP_DIVY: ctl.cmd = sts.rim ? CMD_DIV_INIT : CMD_NOP;
               UOP_POINT: ctl.cmd = CMD_POINT;
               default:   ctl.cmd = CMD_NOP;
            endcase
         end
         ST_ACC:  ctl.cmd = CMD_ACC;
         ST_ITER: ctl.cmd = (uop.kind == UOP_SQRT) ? CMD_SQRT_STEP : CMD_DIV_STEP;
         ST_WAIT: begin
            if (sts.out_free) ctl.cmd = CMD_PUBLISH;
         end
         default: ctl.cmd = CMD_NOP;
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/arc_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module arc_dp
   import arc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire arc_ctl_type             ctl,
   output arc_sts_type                  sts,
   input  wire logic                    req_opcode,
   input  wire logic [COORD_BITS-1:0]   req_screen_x,
   input  wire logic [COORD_BITS-1:0]   req_screen_y,
   input  wire logic                    csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [REG_W-1:0]        csr_wdata,
   input  wire logic                    rsp_stall,
   output logic                         rsp_valid,
   output logic signed [OUT_W-1:0]      rot [NUM_ROT]
);

   logic signed [REG_W-1:0]  cfg_ff [NUM_CFG];
   logic                     op_ff;
   logic [COORD_BITS-1:0]    sx_ff, sy_ff;
   logic signed [ACC_W-1:0]  prod_ff, acc_ff, acc_sum;
   logic signed [BALL_W-1:0] bx_ff, by_ff;
   logic                     neg_x_ff, neg_y_ff, k_ff;
   logic [UX_W-1:0]          ux_ff, uy_ff;
   logic [MAG_W-1:0]         mag_ff, sq_n_ff, sq_res_ff, sq_bit_ff;
   logic [MAG_W:0]           sq_trial;
   logic [DVS_W-1:0]         dv_rem_ff, dv_dvs_ff;
   logic [PT_W-1:0]          quo_x_ff, quo_y_ff;
   logic                     div_y_ff;
   logic signed [ST_W-1:0]   f_ff [3];
   logic signed [ST_W-1:0]   t_ff [3];
   logic signed [ST_W-1:0]   d_ff [4];
   logic signed [ST_W-1:0]   q_ff [4];
   logic signed [ST_W-1:0]   c_ff [4];
   logic signed [ST_W-1:0]   m_ff [NUM_ROT];
   logic signed [OUT_W-1:0]  rot_ff [NUM_ROT];
   logic                     rsp_valid_ff;
   logic signed [OPND_W-1:0] op_a, op_b;
   logic                     rim;
   logic [ROOT_W-1:0]        root, rdiv;
   logic [LIM_BITS:0]        rnd_x, rnd_y;
   logic [ROOT_W:0]          rnd_z;
   logic [PT_W-1:0]          px, py, pz;
   logic signed [ST_W-1:0]   sp_x, sp_y, sp_z;
   logic signed [ACC_W-1:0]  m_val;

   // Round half up to FRAC_BITS fraction bits, then saturate.
   function automatic logic signed [ST_W-1:0] rnd_sat(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      r = (v + HALF_LSB) >>> FRAC_BITS;
      if (r > ST_MAX) r = ST_MAX;
      else if (r < ST_MIN) r = ST_MIN;
      return r[ST_W-1:0];
   endfunction

   function automatic logic signed [ST_W-1:0] pt_sat(input logic [PT_W-1:0] m,
                                                     input logic neg);
      logic signed [PT_W:0] s;
      s = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
      if (s > (PT_W+1)'(ST_MAX)) s = (PT_W+1)'(ST_MAX);
      else if (s < (PT_W+1)'(ST_MIN)) s = (PT_W+1)'(ST_MIN);
      return s[ST_W-1:0];
   endfunction

   function automatic logic signed [OPND_W-1:0] opnd(input arc_opnd_type sel);
      logic signed [OPND_W-1:0] v;
      case (sel)
         OP_R0:  v = cfg_ff[0];
         OP_R1:  v = cfg_ff[1];
         OP_R2:  v = cfg_ff[2];
         OP_R3:  v = cfg_ff[3];
         OP_R4:  v = cfg_ff[4];
         OP_R5:  v = cfg_ff[5];
         OP_SX:  v = OPND_W'(sx_ff);
         OP_SY:  v = OPND_W'(sy_ff);
         OP_ONE: v = OPND_W'(1);
         OP_UX:  v = OPND_W'(ux_ff[LIM_BITS-1:0]);
         OP_UY:  v = OPND_W'(uy_ff[LIM_BITS-1:0]);
         OP_F0:  v = OPND_W'(f_ff[0]);
         OP_F1:  v = OPND_W'(f_ff[1]);
         OP_F2:  v = OPND_W'(f_ff[2]);
         OP_T0:  v = OPND_W'(t_ff[0]);
         OP_T1:  v = OPND_W'(t_ff[1]);
         OP_T2:  v = OPND_W'(t_ff[2]);
         OP_D0:  v = OPND_W'(d_ff[0]);
         OP_D1:  v = OPND_W'(d_ff[1]);
         OP_D2:  v = OPND_W'(d_ff[2]);
         OP_D3:  v = OPND_W'(d_ff[3]);
         OP_Q0:  v = OPND_W'(q_ff[0]);
         OP_Q1:  v = OPND_W'(q_ff[1]);
         OP_Q2:  v = OPND_W'(q_ff[2]);
         OP_Q3:  v = OPND_W'(q_ff[3]);
         OP_C0:  v = OPND_W'(c_ff[0]);
         OP_C1:  v = OPND_W'(c_ff[1]);
         OP_C2:  v = OPND_W'(c_ff[2]);
         OP_C3:  v = OPND_W'(c_ff[3]);
         default: v = '0;
      endcase
      return v;
   endfunction

   always_comb begin
      op_a     = opnd(ctl.a);
      op_b     = opnd(ctl.b);
      acc_sum  = (ctl.first ? '0 : acc_ff) + (ctl.sub ? -prod_ff : prod_ff);
      // Diagonal entries are one minus twice the sum, the rest twice the sum.
      if (ctl.dst == DST_M0 || ctl.dst == DST_M4 || ctl.dst == DST_M8)
         m_val = ONE_SQ - (acc_sum <<< 1);
      else
         m_val = acc_sum <<< 1;
      rim      = k_ff || (mag_ff > ONE_MAG);
      sq_trial = {1'b0, sq_res_ff} + {1'b0, sq_bit_ff};
      root     = sq_res_ff[ROOT_W-1:0];
      rdiv     = (root == '0) ? ROOT_W'(1) : root;
      rnd_x    = {1'b0, ux_ff[LIM_BITS-1:0]} + (LIM_BITS+1)'(1 << (RND_SH - 1));
      rnd_y    = {1'b0, uy_ff[LIM_BITS-1:0]} + (LIM_BITS+1)'(1 << (RND_SH - 1));
      rnd_z    = {1'b0, root} + (ROOT_W+1)'(1 << (RND_SH - 1));
      px       = rim ? quo_x_ff : PT_W'(rnd_x >> RND_SH);
      py       = rim ? quo_y_ff : PT_W'(rnd_y >> RND_SH);
      pz       = rim ? '0 : PT_W'(rnd_z >> RND_SH);
      sp_x     = pt_sat(px, neg_x_ff);
      sp_y     = pt_sat(py, neg_y_ff);
      sp_z     = pt_sat(pz, 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CFG; i++) cfg_ff[i] <= '0;
      end else if (csr_write_en && (csr_index < CSR_INDEX_W'(NUM_CFG))) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   // Sphere points and quaternions.
   always_ff @(posedge clock) begin
      if (reset) begin
         f_ff[0] <= '0;
         f_ff[1] <= '0;
         f_ff[2] <= ST_MAX[ST_W-1:0];
         for (int i = 0; i < 4; i++) begin
            q_ff[i] <= (i == 0) ? ST_MAX[ST_W-1:0] : '0;
            c_ff[i] <= (i == 0) ? ST_MAX[ST_W-1:0] : '0;
         end
      end else begin
         if (ctl.cmd == CMD_LOAD && !req_opcode) begin
            for (int i = 0; i < 4; i++) q_ff[i] <= c_ff[i];
         end
         if (ctl.cmd == CMD_POINT && !op_ff) begin
            f_ff[0] <= sp_x;
            f_ff[1] <= sp_y;
            f_ff[2] <= sp_z;
         end
         if (ctl.cmd == CMD_ACC && ctl.last) begin
            case (ctl.dst)
               DST_C0: c_ff[0] <= rnd_sat(acc_sum);
               DST_C1: c_ff[1] <= rnd_sat(acc_sum);
               DST_C2: c_ff[2] <= rnd_sat(acc_sum);
               DST_C3: c_ff[3] <= rnd_sat(acc_sum);
               default: ;
            endcase
         end
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      case (ctl.cmd)
         CMD_LOAD: begin
            op_ff <= req_opcode;
            sx_ff <= req_screen_x;
            sy_ff <= req_screen_y;
         end
         CMD_MUL: prod_ff <= op_a * op_b;
         CMD_ACC: begin
            acc_ff <= acc_sum;
            if (ctl.last) begin
               case (ctl.dst)
                  DST_BX:  bx_ff <= acc_sum[BALL_W-1:0];
                  DST_BY:  by_ff <= acc_sum[BALL_W-1:0];
                  DST_MAG: mag_ff <= acc_sum[MAG_W-1:0];
                  DST_D0:  d_ff[0] <= rnd_sat(acc_sum);
                  DST_D1:  d_ff[1] <= rnd_sat(acc_sum);
                  DST_D2:  d_ff[2] <= rnd_sat(acc_sum);
                  DST_D3:  d_ff[3] <= rnd_sat(acc_sum);
                  DST_M0:  m_ff[0] <= rnd_sat(m_val);
                  DST_M1:  m_ff[1] <= rnd_sat(m_val);
                  DST_M2:  m_ff[2] <= rnd_sat(m_val);
                  DST_M3:  m_ff[3] <= rnd_sat(m_val);
                  DST_M4:  m_ff[4] <= rnd_sat(m_val);
                  DST_M5:  m_ff[5] <= rnd_sat(m_val);
                  DST_M6:  m_ff[6] <= rnd_sat(m_val);
                  DST_M7:  m_ff[7] <= rnd_sat(m_val);
                  DST_M8:  m_ff[8] <= rnd_sat(m_val);
                  default: ;
               endcase
            end
         end
         CMD_ABS: begin
            neg_x_ff <= bx_ff[BALL_W-1];
            neg_y_ff <= by_ff[BALL_W-1];
            ux_ff    <= bx_ff[BALL_W-1] ? UX_W'(-bx_ff) : bx_ff[UX_W-1:0];
            uy_ff    <= by_ff[BALL_W-1] ? UX_W'(-by_ff) : by_ff[UX_W-1:0];
            k_ff     <= 1'b0;
         end
         CMD_SHIFT: begin
            ux_ff <= ux_ff >> 1;
            uy_ff <= uy_ff >> 1;
            k_ff  <= 1'b1;
         end
         CMD_SQRT_INIT: begin
            sq_n_ff   <= rim ? mag_ff : ONE_MAG - mag_ff;
            sq_res_ff <= '0;
            sq_bit_ff <= MAG_W'(1) << (2 * LIM_BITS);
         end
         CMD_SQRT_STEP: begin
            if ({1'b0, sq_n_ff} >= sq_trial) begin
               sq_n_ff   <= sq_n_ff - sq_trial[MAG_W-1:0];
               sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_ff <= sq_res_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
         end
         CMD_DIV_INIT: begin
            div_y_ff  <= ctl.div_y;
            dv_rem_ff <= (DVS_W'(ctl.div_y ? uy_ff[LIM_BITS-1:0] : ux_ff[LIM_BITS-1:0])
                          << FRAC_BITS) + DVS_W'(rdiv >> 1);
            dv_dvs_ff <= DVS_W'(rdiv) << (DIV_STEPS - 1);
            if (ctl.div_y) quo_y_ff <= '0;
            else           quo_x_ff <= '0;
         end
         CMD_DIV_STEP: begin
            if (dv_rem_ff >= dv_dvs_ff) dv_rem_ff <= dv_rem_ff - dv_dvs_ff;
            if (div_y_ff) quo_y_ff <= {quo_y_ff[PT_W-2:0], dv_rem_ff >= dv_dvs_ff};
            else          quo_x_ff <= {quo_x_ff[PT_W-2:0], dv_rem_ff >= dv_dvs_ff};
            dv_dvs_ff <= dv_dvs_ff >> 1;
         end
         CMD_POINT: begin
            if (op_ff) begin
               t_ff[0] <= sp_x;
               t_ff[1] <= sp_y;
               t_ff[2] <= sp_z;
            end
         end
         default: ;
      endcase
   end

   // Output register: hold the word until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.cmd == CMD_PUBLISH) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.cmd == CMD_PUBLISH) begin
         for (int i = 0; i < NUM_ROT; i++) rot_ff[i] <= OUT_W'(m_ff[i]);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rot            = rot_ff;
   assign sts.begin_drag = !op_ff;
   assign sts.big        = |ux_ff[UX_W-1:LIM_BITS] || |uy_ff[UX_W-1:LIM_BITS];
   assign sts.rim        = rim;
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

endmodule

`default_nettype wire

>>> rtl/arc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module arc_checker
   import arc_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic signed [OUT_W-1:0] rsp_rot_00,
   input wire logic signed [OUT_W-1:0] rsp_rot_22
);

   // One word at a time: an accepted word closes the input.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input open right after accepting a word");

   // A new result only appears at the end of a busy period.
   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without work in flight");

   // Reset empties the block.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("block not idle after reset");

   // Stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_rot_00) && $stable(rsp_rot_22)))
      else $error("stalled result word changed");

endmodule

bind arcball_drag_rotation_unit arc_checker u_arc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_rot_00 (rsp_rot_00),
   .rsp_rot_22 (rsp_rot_22)
);

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps

// Scoreboard: tracks the arcball state, predicts the rotation matrix for
// every accepted pointer word and checks each returned matrix in order.
class arcball_scoreboard;
   longint        gain [6];
   longint        down_pt [3];
   longint        down_q [4];
   longint        cur_q [4];
   logic [8:0][15:0] matrix_q [$];
   int            errors;

   function new();
      foreach (gain[i]) gain[i] = 0;
      down_pt = '{0, 0, 32767};
      down_q  = '{32767, 0, 0, 0};
      cur_q   = '{32767, 0, 0, 0};
      errors  = 0;
   endfunction

   function void set_gain(int idx, logic [31:0] val);
      gain[idx] = longint'(signed'(val));
   endfunction

   static function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   static function longint to_state(longint v);
      return clip((v + 64'sd16384) >>> 15, -32768, 32767);
   endfunction

   static function longint unsigned floor_root(longint unsigned n);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Map the screen point onto the ball; rim projection outside the disc.
   function void to_ball(longint sx, longint sy, output longint p [3]);
      longint bx, by;
      longint unsigned ux, uy, mag, r, px, py, pz;
      bit nx, ny;
      int k;
      bx = gain[0] * sx + gain[1] * sy + gain[2];
      by = gain[3] * sx + gain[4] * sy + gain[5];
      nx = bx < 0;
      ny = by < 0;
      ux = nx ? -bx : bx;
      uy = ny ? -by : by;
      k  = 0;
      while (ux >= (64'd1 << 30) || uy >= (64'd1 << 30)) begin
         ux >>= 1;
         uy >>= 1;
         k++;
      end
      mag = ux * ux + uy * uy;
      if (k > 0 || mag > (64'd1 << 48)) begin
         r = floor_root(mag);
         if (r == 0) r = 1;
         px = ((ux << 15) + r / 2) / r;
         py = ((uy << 15) + r / 2) / r;
         pz = 0;
      end else begin
         px = (ux + 256) >> 9;
         py = (uy + 256) >> 9;
         pz = (floor_root((64'd1 << 48) - mag) + 256) >> 9;
      end
      p[0] = clip(nx ? -longint'(px) : longint'(px), -32768, 32767);
      p[1] = clip(ny ? -longint'(py) : longint'(py), -32768, 32767);
      p[2] = clip(longint'(pz), -32768, 32767);
   endfunction

   function void note_word(bit op, longint sx, longint sy);
      longint t [3], d [4], m [9];
      longint w, x, y, z, one;
      logic [8:0][15:0] mat;
      if (op == 1'b0) begin
         down_q = cur_q;
         to_ball(sx, sy, down_pt);
      end else begin
         to_ball(sx, sy, t);
         d[0] = to_state(down_pt[0]*t[0] + down_pt[1]*t[1] + down_pt[2]*t[2]);
         d[1] = to_state(down_pt[1]*t[2] - down_pt[2]*t[1]);
         d[2] = to_state(down_pt[2]*t[0] - down_pt[0]*t[2]);
         d[3] = to_state(down_pt[0]*t[1] - down_pt[1]*t[0]);
         cur_q[0] = to_state(d[0]*down_q[0] - d[1]*down_q[1] - d[2]*down_q[2]
                             - d[3]*down_q[3]);
         cur_q[1] = to_state(d[0]*down_q[1] + d[1]*down_q[0] + d[2]*down_q[3]
                             - d[3]*down_q[2]);
         cur_q[2] = to_state(d[0]*down_q[2] - d[1]*down_q[3] + d[2]*down_q[0]
                             + d[3]*down_q[1]);
         cur_q[3] = to_state(d[0]*down_q[3] + d[1]*down_q[2] - d[2]*down_q[1]
                             + d[3]*down_q[0]);
      end
      w = cur_q[0]; x = cur_q[1]; y = cur_q[2]; z = cur_q[3];
      one = 64'sd1 << 30;
      m[0] = one - 2 * (y*y + z*z);
      m[1] = 2 * (x*y + w*z);
      m[2] = 2 * (x*z - w*y);
      m[3] = 2 * (x*y - w*z);
      m[4] = one - 2 * (x*x + z*z);
      m[5] = 2 * (y*z + w*x);
      m[6] = 2 * (x*z + w*y);
      m[7] = 2 * (y*z - w*x);
      m[8] = one - 2 * (x*x + y*y);
      foreach (m[i]) mat[i] = 16'(clip((m[i] + 64'sd16384) >>> 15, -32768, 32767));
      matrix_q.push_back(mat);
   endfunction

   function void check_word(logic [8:0][15:0] got);
      logic [8:0][15:0] want;
      string names [9];
      names = '{"rot_00", "rot_01", "rot_02", "rot_10", "rot_11", "rot_12",
                "rot_20", "rot_21", "rot_22"};
      if (matrix_q.size() == 0) begin
         $error("unexpected result word");
         errors++;
         return;
      end
      want = matrix_q.pop_front();
      for (int i = 0; i < 9; i++)
         if (got[i] !== want[i]) begin
            $error("%s expected %0d actual %0d", names[i],
                   $signed(want[i]), $signed(got[i]));
            errors++;
         end
   endfunction
endclass

module tb;
   import arc_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_opcode = 1'b0;
   logic [COORD_BITS-1:0] req_screen_x = '0;
   logic [COORD_BITS-1:0] req_screen_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [OUT_W-1:0] rsp_rot_00, rsp_rot_01, rsp_rot_02;
   logic signed [OUT_W-1:0] rsp_rot_10, rsp_rot_11, rsp_rot_12;
   logic signed [OUT_W-1:0] rsp_rot_20, rsp_rot_21, rsp_rot_22;
   logic csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [REG_W-1:0] csr_wdata = '0;

   arcball_scoreboard sb = new();
   int idle_cycles = 0;
   int stall_mode = 0;
   int stall_count = 0;
   int burst_left = 0;

   arcball_drag_rotation_unit i_dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // Monitor both channels at the edge; words move on valid high, stall low.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_word(req_opcode, longint'(req_screen_x), longint'(req_screen_y));
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word({rsp_rot_22, rsp_rot_21, rsp_rot_20, rsp_rot_12, rsp_rot_11,
                        rsp_rot_10, rsp_rot_02, rsp_rot_01, rsp_rot_00});
   end

   // Receiver back-pressure: rotate between free-flowing, light and heavy stall.
   always @(posedge clock) begin
      stall_count <= stall_count + 1;
      if (stall_count % 700 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Watchdog: count cycles without any word moving on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("arcball_drag_rotation_unit verification failed");
         $finish;
      end
   end

   // Present one pointer word and hold it until accepted.
   task automatic send_word(bit op, logic [COORD_BITS-1:0] sx, logic [COORD_BITS-1:0] sy);
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_screen_x <= sx;
      req_screen_y <= sy;
      do @(posedge clock); while (req_stall);
   endtask

   // Send with burst/gap pacing: drop valid for a random gap between bursts.
   task automatic paced_word(bit op, logic [COORD_BITS-1:0] sx,
                             logic [COORD_BITS-1:0] sy);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
      burst_left--;
      send_word(op, sx, sy);
   endtask

   // Drop valid and wait for all expected results to return before going on.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.matrix_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_gain(int idx, logic [31:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_INDEX_W'(idx);
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.set_gain(idx, val);
   endtask

   task automatic load_map(logic [31:0] v0, logic [31:0] v1, logic [31:0] v2,
                           logic [31:0] v3, logic [31:0] v4, logic [31:0] v5);
      drain();
      write_gain(0, v0);
      write_gain(1, v1);
      write_gain(2, v2);
      write_gain(3, v3);
      write_gain(4, v4);
      write_gain(5, v5);
   endtask

   // Random traffic: mostly begin-drag followed by a run of drags, some noise.
   task automatic random_traffic(int count);
      int n, run;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 7) == 0) begin
            paced_word(1'($urandom_range(0, 1)), COORD_BITS'($urandom),
                       COORD_BITS'($urandom));
            n++;
         end else begin
            paced_word(1'b0, COORD_BITS'($urandom), COORD_BITS'($urandom));
            run = $urandom_range(1, 8);
            for (int i = 0; i < run; i++)
               paced_word(1'b1, COORD_BITS'($urandom), COORD_BITS'($urandom));
            n += run + 1;
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero map: every point lands on the pole; drag before any begin-drag.
      send_word(1'b1, 12'd0, 12'd0);
      send_word(1'b0, 12'hFFF, 12'hFFF);
      send_word(1'b1, 12'hFFF, 12'd0);

      // Nominal map: screen spans about -1..1 on both axes, y flipped.
      load_map(32'd8192, 32'd0, -32'sd16777216, 32'd0, -32'sd8192, 32'd16777216);
      send_word(1'b0, 12'd2048, 12'd2048);
      send_word(1'b1, 12'd3000, 12'd2048);
      send_word(1'b1, 12'd4095, 12'd4095);
      send_word(1'b1, 12'd0, 12'd0);
      send_word(1'b0, 12'd0, 12'd4095);
      send_word(1'b1, 12'd2048, 12'd100);
      send_word(1'b1, 12'd2048, 12'd2048);
      send_word(1'b0, 12'd4095, 12'd2048);
      send_word(1'b1, 12'd0, 12'd2048);
      random_traffic(200);

      // Extreme maps: far outside the disc, range reduction in play.
      load_map(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
               32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_word(1'b0, 12'd0, 12'd0);
      send_word(1'b1, 12'hFFF, 12'hFFF);
      random_traffic(60);
      load_map(32'h80000000, 32'h80000000, 32'h80000000,
               32'h7FFFFFFF, 32'h80000000, 32'h00000000);
      send_word(1'b0, 12'hFFF, 12'd0);
      send_word(1'b1, 12'd0, 12'hFFF);
      random_traffic(60);

      // Random maps of moderate scale, then fully random coefficients.
      repeat (3) begin
         load_map(32'($urandom_range(0, 32767)) - 32'd16384,
                  32'($urandom_range(0, 32767)) - 32'd16384,
                  32'($urandom_range(0, 67108864)) - 32'd33554432,
                  32'($urandom_range(0, 32767)) - 32'd16384,
                  32'($urandom_range(0, 32767)) - 32'd16384,
                  32'($urandom_range(0, 67108864)) - 32'd33554432);
         random_traffic(180);
      end
      load_map($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      random_traffic(100);

      drain();
      repeat (300) @(posedge clock);
      if (sb.errors == 0 && sb.matrix_q.size() == 0)
         $display("arcball_drag_rotation_unit verification clean");
      else
         $display("arcball_drag_rotation_unit verification failed");
      $finish;
   end
endmodule
